// ===== design/abtt_pkg.sv =====
// Shared constants and types for the array-based binary tree block.
// No dependencies; the interfaces, the top level and the checker use this package.
package abtt_pkg;

  localparam int TREE_LEVELS = 6;
  localparam int NODE_COUNT  = (1 << TREE_LEVELS) - 1;
  localparam int IDX_W       = TREE_LEVELS;
  localparam int DATA_W      = 32;
  localparam int PATH_W      = 6;
  localparam int LEVEL_W     = 3;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [IDX_W:0]   child_t;

  typedef enum logic [1:0] {
    OP_INSERT    = 2'd0,
    OP_PREORDER  = 2'd1,
    OP_POSTORDER = 2'd2,
    OP_INORDER   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_VALUE    = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NO_FREE  = 2'd3
  } status_t;

endpackage

// ===== design/abtt_cmd_if.sv =====
// Command channel (insert or traversal request) with valid/ready handshake.
// Depends on abtt_pkg for field types and widths.
interface abtt_cmd_if;
  logic                            valid;
  logic                            ready;
  abtt_pkg::op_t                   operation;
  logic signed [abtt_pkg::DATA_W-1:0] data;
  logic [abtt_pkg::PATH_W-1:0]     path;

  modport source (output valid, output operation, output data, output path, input ready);
  modport sink   (input valid, input operation, input data, input path, output ready);
endinterface

// ===== design/abtt_rsp_if.sv =====
// Result channel (inserted, traversal value, status) with valid/ready handshake.
// Depends on abtt_pkg for field types and widths.
interface abtt_rsp_if;
  logic                            valid;
  logic                            ready;
  logic signed [abtt_pkg::DATA_W-1:0] value;
  abtt_pkg::status_t               status;
  logic                            last;

  modport source (output valid, output value, output status, output last, input ready);
  modport sink   (input valid, input value, input status, input last, output ready);
endinterface

// ===== design/abtt_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module abtt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 63
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/array_binary_tree_traversal.sv =====
// Array-based binary tree: heap-indexed node store with insert and traversals.
// Depends on abtt_pkg, abtt_cmd_if, abtt_rsp_if and abtt_ram.
//
// Usage:
//   cmd carries one request per transfer: operation (insert, preorder,
//   postorder, inorder), data (value to insert) and path (left/right bits).
//   rsp returns the results of that request; last marks the final one.
//   An insert gives one result: inserted, or no free node on its path.
//   A traversal gives one result per stored node, or one tree-empty result.
// Timing:
//   cmd.ready is high only while the sequencer is idle; one request is
//   worked on at a time. An insert walks its path one tree level at a
//   time through the shared child-index unit. A traversal steps one node
//   edge or phase at a time and reads each value that it emits from the
//   single-read-port node RAM.
//   The final result sits in an output register, so the next request is
//   taken while it still waits for rsp.ready. A stalled receiver stalls the
//   sequencer when a further value must be handed over.
// Reset:
//   rst clears all node valid bits (tree empty) and drops any pending result.
module array_binary_tree_traversal (
  input  logic       clk,
  input  logic       rst,
  abtt_cmd_if.sink   cmd,
  abtt_rsp_if.source rsp
);
  import abtt_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_INSERT = 5'b00010,
    S_WALK   = 5'b00100,
    S_EMIT   = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  typedef enum logic [2:0] {
    P_ENTER       = 3'b001,
    P_AFTER_LEFT  = 3'b010,
    P_AFTER_RIGHT = 3'b100
  } phase_t;

  state_t                  state;
  phase_t                  phase;
  idx_t                    idx;
  logic [LEVEL_W-1:0]      lvl;
  op_t                     order;
  logic [PATH_W-1:0]       path_r;
  logic [DATA_W-1:0]       data_r;
  logic                    done;
  logic [NODE_COUNT-1:0]   valid;
  logic [DATA_W-1:0]       pend_value;
  logic                    pend_valid;
  status_t                 fin_status;
  logic                    out_valid;
  logic [DATA_W-1:0]       out_value;
  status_t                 out_status;
  logic                    out_last;

  logic                    cmd_fire;
  logic                    out_free;
  logic                    out_load;
  child_t                  left;
  child_t                  right;
  child_t                  ins_child;
  logic                    left_ok;
  logic                    right_ok;
  logic                    ins_free;
  idx_t                    parent;
  logic                    emit_here;

  logic                    ram_we;
  idx_t                    ram_waddr;
  logic [DATA_W-1:0]       ram_wdata;
  logic                    ram_re;
  logic [DATA_W-1:0]       ram_rdata;

  assign cmd.ready  = (state == S_IDLE);
  assign cmd_fire   = cmd.valid && cmd.ready;
  assign out_free   = !out_valid || rsp.ready;
  assign out_load   = out_free && ((state == S_FINISH) || ((state == S_EMIT) && pend_valid));

  assign rsp.valid  = out_valid;
  assign rsp.value  = out_value;
  assign rsp.status = out_status;
  assign rsp.last   = out_last;

  assign left      = {idx, 1'b1};
  assign right     = child_t'({idx, 1'b0}) + child_t'(2);
  assign ins_child = path_r[lvl] ? right : left;
  assign left_ok   = (left < child_t'(NODE_COUNT)) && valid[left[IDX_W-1:0]];
  assign right_ok  = (right < child_t'(NODE_COUNT)) && valid[right[IDX_W-1:0]];
  assign ins_free  = (ins_child < child_t'(NODE_COUNT)) && !valid[ins_child[IDX_W-1:0]];
  assign parent    = (idx - idx_t'(1)) >> 1;

  assign emit_here = ((phase == P_ENTER)       && (order == OP_PREORDER))  ||
                     ((phase == P_AFTER_LEFT)  && (order == OP_INORDER))   ||
                     ((phase == P_AFTER_RIGHT) && (order == OP_POSTORDER));

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ins_child[IDX_W-1:0];
    ram_wdata = data_r;
    if (state == S_IDLE) begin
      ram_we    = cmd_fire && (cmd.operation == OP_INSERT) && !valid[0];
      ram_waddr = '0;
      ram_wdata = cmd.data;
    end else if (state == S_INSERT) begin
      ram_we = ins_free;
    end
  end

  assign ram_re = (state == S_WALK) && emit_here && !done;

  abtt_ram #(
    .WIDTH (DATA_W),
    .DEPTH (NODE_COUNT)
  ) u_node_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
      valid      <= '0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_fire) begin
            order  <= cmd.operation;
            path_r <= cmd.path;
            data_r <= cmd.data;
            idx    <= '0;
            lvl    <= '0;
            phase  <= P_ENTER;
            done   <= 1'b0;
            if (cmd.operation == OP_INSERT) begin
              if (!valid[0]) begin
                valid[0]   <= 1'b1;
                fin_status <= ST_INSERTED;
                state      <= S_FINISH;
              end else if (TREE_LEVELS == 1) begin
                fin_status <= ST_NO_FREE;
                state      <= S_FINISH;
              end else begin
                state <= S_INSERT;
              end
            end else begin
              fin_status <= ST_EMPTY;
              state      <= valid[0] ? S_WALK : S_FINISH;
            end
          end
        end
        S_INSERT: begin
          if (ins_free) begin
            valid[ins_child[IDX_W-1:0]] <= 1'b1;
            fin_status                  <= ST_INSERTED;
            state                       <= S_FINISH;
          end else if (lvl == LEVEL_W'(TREE_LEVELS - 2)) begin
            fin_status <= ST_NO_FREE;
            state      <= S_FINISH;
          end else begin
            idx <= ins_child[IDX_W-1:0];
            lvl <= lvl + LEVEL_W'(1);
          end
        end
        S_WALK: begin
          if (emit_here && !done) begin
            state <= S_EMIT;
          end else begin
            done <= 1'b0;
            unique case (phase)
              P_ENTER: begin
                if (left_ok) begin
                  idx <= left[IDX_W-1:0];
                end else begin
                  phase <= P_AFTER_LEFT;
                end
              end
              P_AFTER_LEFT: begin
                if (right_ok) begin
                  idx   <= right[IDX_W-1:0];
                  phase <= P_ENTER;
                end else begin
                  phase <= P_AFTER_RIGHT;
                end
              end
              P_AFTER_RIGHT: begin
                if (idx == '0) begin
                  state <= S_FINISH;
                end else begin
                  idx   <= parent;
                  phase <= idx[0] ? P_AFTER_LEFT : P_AFTER_RIGHT;
                end
              end
              default: phase <= P_ENTER;
            endcase
          end
        end
        S_EMIT: begin
          if (!pend_valid || out_free) begin
            if (pend_valid) begin
              out_value  <= pend_value;
              out_status <= ST_VALUE;
              out_last   <= 1'b0;
            end
            pend_value <= ram_rdata;
            pend_valid <= 1'b1;
            done       <= 1'b1;
            state      <= S_WALK;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            out_last  <= 1'b1;
            if (pend_valid) begin
              out_value  <= pend_value;
              out_status <= ST_VALUE;
            end else begin
              out_value  <= '0;
              out_status <= fin_status;
            end
            pend_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== design/abtt_checker.sv =====
// Port-level checks for array_binary_tree_traversal, attached with bind.
// Depends on abtt_pkg for status codes.
module abtt_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           cmd_valid,
  input logic                           cmd_ready,
  input logic                           rsp_valid,
  input logic                           rsp_ready,
  input logic [abtt_pkg::DATA_W-1:0]    rsp_value,
  input logic [1:0]                     rsp_status,
  input logic                           rsp_last
);
  import abtt_pkg::*;

  a_busy_after_cmd: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("cmd ready right after a command transfer");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value) &&
      $stable(rsp_status) && $stable(rsp_last))
    else $error("stalled result changed");

  a_only_values_continue: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_last |-> rsp_status == ST_VALUE)
    else $error("non-final result that is not a traversal value");

  a_status_value_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != ST_VALUE |-> rsp_value == '0 && rsp_last)
    else $error("status result with nonzero value or not final");

endmodule

bind array_binary_tree_traversal abtt_checker u_abtt_checker (
  .clk        (clk),
  .rst        (rst),
  .cmd_valid  (cmd.valid),
  .cmd_ready  (cmd.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .rsp_value  (rsp.value),
  .rsp_status (rsp.status),
  .rsp_last   (rsp.last)
);

// ===== tb/sv/tb.sv =====
// Self-checking bench for array_binary_tree_traversal: inserts and traversals.
// Tracks its own copy of the tree. Every response is compared with the queue of predicted results.
// Depends on abtt_pkg, abtt_cmd_if, abtt_rsp_if and the design top level.
module tb;
  import abtt_pkg::*;

  localparam int PH_FREE = 0;
  localparam int PH_SEND = 1;
  localparam int PH_RECV = 2;
  localparam int PH_BOTH = 3;
  localparam int PH_HOLD = 4;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    op_t                      op;
    logic signed [DATA_W-1:0] data;
    logic [PATH_W-1:0]        path;
    int                       phase;
  } tree_cmd_t;

  typedef struct {
    logic signed [DATA_W-1:0] value;
    status_t                  status;
    logic                     last;
  } tree_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  abtt_cmd_if cmd_ch();
  abtt_rsp_if rsp_ch();

  array_binary_tree_traversal dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .rsp (rsp_ch)
  );

  tree_cmd_t                pending_q[$];
  tree_res_t                tree_results_q[$];
  logic signed [DATA_W-1:0] node_val[NODE_COUNT];
  bit                       occupied[NODE_COUNT];
  int                       send_pct[5] = '{0, 49, 0, 35, 0};
  int                       recv_pct[5] = '{0, 0, 49, 35, 0};
  int                       cur_phase = PH_FREE;
  int                       hold_left = 0;
  bit                       hold_done = 1'b0;
  int                       errors = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    cmd_ch.valid     = 1'b0;
    cmd_ch.operation = OP_INSERT;
    cmd_ch.data      = '0;
    cmd_ch.path      = '0;
    rsp_ch.ready     = 1'b0;
    foreach (occupied[i]) begin
      occupied[i] = 1'b0;
      node_val[i] = '0;
    end
  end

  function automatic bit coin(int pct);
    return $urandom_range(99) < pct;
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch: %s", what);
    errors++;
  endtask

  function automatic void visit_node(int node, op_t order);
    tree_res_t r;
    if (node >= NODE_COUNT || !occupied[node]) return;
    r = '{node_val[node], ST_VALUE, 1'b0};
    if (order == OP_PREORDER) tree_results_q.push_back(r);
    visit_node(2 * node + 1, order);
    if (order == OP_INORDER) tree_results_q.push_back(r);
    visit_node(2 * node + 2, order);
    if (order == OP_POSTORDER) tree_results_q.push_back(r);
  endfunction

  function automatic void predict_tree(op_t op, logic signed [DATA_W-1:0] d,
                                       logic [PATH_W-1:0] p);
    int        node;
    int        lvl;
    int        before_cnt;
    status_t   st;
    tree_res_t r;
    node = 0;
    st = ST_NO_FREE;
    if (op == OP_INSERT) begin
      if (!occupied[0]) begin
        st = ST_INSERTED;
      end else begin
        for (lvl = 1; lvl < TREE_LEVELS; lvl++) begin
          node = 2 * node + 1 + p[lvl-1];
          if (node < NODE_COUNT && !occupied[node]) begin
            st = ST_INSERTED;
            break;
          end
        end
      end
      if (st == ST_INSERTED) begin
        node_val[node] = d;
        occupied[node] = 1'b1;
      end
      tree_results_q.push_back('{'0, st, 1'b1});
    end else begin
      before_cnt = tree_results_q.size();
      visit_node(0, op);
      if (tree_results_q.size() == before_cnt) begin
        tree_results_q.push_back('{'0, ST_EMPTY, 1'b1});
      end else begin
        r = tree_results_q.pop_back();
        r.last = 1'b1;
        tree_results_q.push_back(r);
      end
    end
  endfunction

  task automatic add_cmd(op_t op, logic signed [DATA_W-1:0] d, logic [PATH_W-1:0] p,
                         int ph);
    pending_q.push_back('{op, d, p, ph});
  endtask

  always @(posedge clk) begin
    tree_cmd_t nxt;
    if (rst) begin
      cmd_ch.valid <= 1'b0;
    end else begin
      if (cmd_ch.valid && cmd_ch.ready) begin
        predict_tree(cmd_ch.operation, cmd_ch.data, cmd_ch.path);
      end
      if (!cmd_ch.valid || cmd_ch.ready) begin
        if (pending_q.size() != 0 && !coin(send_pct[pending_q[0].phase])) begin
          nxt = pending_q.pop_front();
          cmd_ch.valid     <= 1'b1;
          cmd_ch.operation <= nxt.op;
          cmd_ch.data      <= nxt.data;
          cmd_ch.path      <= nxt.path;
          cur_phase        <= nxt.phase;
        end else begin
          cmd_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && cur_phase == PH_HOLD) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  always @(posedge clk) begin
    tree_res_t exp_r;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (tree_results_q.size() == 0) begin
          report_mismatch($sformatf("unexpected transfer value=%0d status=%0d last=%0b",
                                    rsp_ch.value, rsp_ch.status, rsp_ch.last));
        end else begin
          exp_r = tree_results_q.pop_front();
          if (rsp_ch.value !== exp_r.value)
            report_mismatch($sformatf("value %0d, expected %0d", rsp_ch.value, exp_r.value));
          if (rsp_ch.status !== exp_r.status)
            report_mismatch($sformatf("status %0d, expected %0d", rsp_ch.status,
                                      exp_r.status));
          if (rsp_ch.last !== exp_r.last)
            report_mismatch($sformatf("last %0b, expected %0b", rsp_ch.last, exp_r.last));
        end
      end
      rsp_ch.ready <= (hold_left == 0) && !coin(recv_pct[cur_phase]);
    end
  end

  initial begin
    int   ph;
    int   k;
    op_t  op;
    logic signed [DATA_W-1:0] d;

    add_cmd(OP_PREORDER, 32'sd7, 6'd0, PH_FREE);
    add_cmd(OP_POSTORDER, -32'sd7, 6'd63, PH_FREE);
    add_cmd(OP_INORDER, 32'sd0, 6'd21, PH_FREE);
    add_cmd(OP_INSERT, 32'sh7FFF_FFFF, 6'd63, PH_FREE);
    add_cmd(OP_INSERT, -32'sd1, 6'd0, PH_FREE);
    add_cmd(OP_INSERT, 32'sh8000_0000, 6'd0, PH_FREE);
    add_cmd(OP_INSERT, 32'sd0, 6'd0, PH_FREE);
    add_cmd(OP_INSERT, 32'sd5, 6'd0, PH_FREE);
    add_cmd(OP_INSERT, 32'sd6, 6'd0, PH_FREE);
    add_cmd(OP_INSERT, 32'sd99, 6'd0, PH_FREE);
    for (k = 0; k < 5; k++) add_cmd(OP_INSERT, $urandom, 6'd63, PH_FREE);
    add_cmd(OP_INSERT, 32'sd123, 6'd63, PH_FREE);
    add_cmd(OP_INSERT, $urandom, 6'b101010, PH_FREE);
    add_cmd(OP_INSERT, $urandom, 6'b010101, PH_FREE);
    add_cmd(OP_PREORDER, 32'sd0, 6'd0, PH_FREE);
    add_cmd(OP_POSTORDER, 32'sd0, 6'd0, PH_FREE);
    add_cmd(OP_INORDER, 32'sd0, 6'd0, PH_FREE);

    for (k = 0; k < 90; k++) begin
      ph = (k < 80) ? k / 20 : PH_HOLD;
      if (ph == PH_HOLD ? $urandom_range(3) != 0 : $urandom_range(9) < 3)
        op = op_t'($urandom_range(1, 3));
      else
        op = OP_INSERT;
      case ($urandom_range(9))
        0: d = 32'sh8000_0000;
        1: d = 32'sh7FFF_FFFF;
        default: d = $urandom;
      endcase
      add_cmd(op, d, $urandom_range(63), ph);
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    while (pending_q.size() != 0 || cmd_ch.valid) @(posedge clk);
    while (tree_results_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0) begin
      $display("[array_binary_tree_traversal] OK");
    end else begin
      $display("[array_binary_tree_traversal] ERROR");
    end
    $finish;
  end

  initial begin
    #(12 * 400000);
    $display("[array_binary_tree_traversal] ERROR");
    $finish;
  end
endmodule

// ===== array_binary_tree_traversal.f =====
design/abtt_pkg.sv
design/abtt_cmd_if.sv
design/abtt_rsp_if.sv
design/abtt_ram.sv
design/array_binary_tree_traversal.sv
design/abtt_checker.sv
tb/sv/tb.sv
